/* rtl/core/afrlrc_pkg.sv */
// ----------------------------------------------------------------------------
// afrlrc_pkg
// shared types, character codes and helpers for the ascii frame receiver
// ----------------------------------------------------------------------------
package afrlrc_pkg;

  localparam logic [7:0] START_CHAR = 8'h40;
  localparam logic [7:0] END_CHAR   = 8'h09;
  localparam logic [7:0] CR_CHAR    = 8'h0D;

  // frame status codes
  localparam logic [1:0] FS_OK        = 2'd0;
  localparam logic [1:0] FS_LRC_ERR   = 2'd1;
  localparam logic [1:0] FS_ADDR_ERR  = 2'd2;
  localparam logic [1:0] FS_TOO_SHORT = 2'd3;

  // bytes a frame needs ahead of the end char to carry the lrc
  localparam int unsigned MIN_FRAME_BYTES = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } afrlrc_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic walk;
    logic emit;
  } afrlrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic walk_last;
    logic out_free;
  } afrlrc_sts_t;

  // nibble to uppercase ascii hex
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

endpackage

/* rtl/core/afrlrc_ctrl.sv */
// ----------------------------------------------------------------------------
// afrlrc_ctrl
// sequencer: takes bytes, walks the buffer at a frame end, emits the result
// ----------------------------------------------------------------------------
module afrlrc_ctrl
  import afrlrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  afrlrc_sts_t sts,
  output afrlrc_cmd_t cmd
);

  afrlrc_state_t state;
  afrlrc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && sts.frame_end) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/core/afrlrc_dp.sv */
// ----------------------------------------------------------------------------
// afrlrc_dp
// frame buffer, byte count, lrc accumulator and result register
// ----------------------------------------------------------------------------
module afrlrc_dp
  import afrlrc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  afrlrc_cmd_t cmd,
  output afrlrc_sts_t sts,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [7:0]  command_byte,
  output logic [7:0]  address_byte,
  output logic [7:0]  data_byte_0,
  output logic [7:0]  data_byte_1,
  output logic [7:0]  data_byte_2,
  output logic [3:0]  frame_length,
  output logic [15:0] computed_lrc
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned EXT_W = CNT_W + 1;

  logic [7:0]       frame_buf [MAX_FRAME_BYTES];
  logic [CNT_W-1:0] byte_count;
  logic             last_cr;
  logic [CNT_W-1:0] end_count;
  logic [CNT_W-1:0] walk_idx;
  logic [7:0]       lrc_sum;
  logic [7:0]       got_hi;
  logic [7:0]       got_lo;
  logic [7:0]       own_addr;

  logic             is_start;
  logic             is_end;
  logic             end_ok;
  logic [7:0]       walk_byte;
  logic [EXT_W-1:0] idx_ext;
  logic [EXT_W-1:0] end_ext;
  logic             in_sum;
  logic [7:0]       lrc_val;
  logic [15:0]      lrc_chars;
  logic [1:0]       status_val;
  logic [4:0]       len_sum;

  assign is_start = (rx_byte == START_CHAR);
  assign is_end   = (rx_byte == END_CHAR);
  // an end char counts only right after a stored carriage return
  assign end_ok   = is_end && (byte_count != '0) && last_cr;

  assign walk_byte = frame_buf[walk_idx];
  assign idx_ext   = EXT_W'(walk_idx);
  assign end_ext   = EXT_W'(end_count);
  // lrc covers bytes 1 .. end-4
  assign in_sum    = (walk_idx != '0) && ((idx_ext + EXT_W'(4)) <= end_ext);

  assign sts.frame_end = end_ok;
  assign sts.walk_last = ((idx_ext + EXT_W'(1)) == end_ext);
  assign sts.out_free  = !out_valid || !out_stall;

  assign lrc_val   = 8'd0 - lrc_sum;
  assign lrc_chars = {hex_char(lrc_val[7:4]), hex_char(lrc_val[3:0])};
  assign len_sum   = 5'(end_count) + 5'd1;

  always_comb begin
    priority if (end_count < CNT_W'(MIN_FRAME_BYTES)) begin
      status_val = FS_TOO_SHORT;
    end else if (frame_buf[2] != own_addr) begin
      status_val = FS_ADDR_ERR;
    end else if (lrc_chars != {got_hi, got_lo}) begin
      status_val = FS_LRC_ERR;
    end else begin
      status_val = FS_OK;
    end
  end

  // address register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= 8'h31;
    end else if (cfg_valid) begin
      own_addr <= cfg_data;
    end
  end

  // byte intake
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
        frame_buf[i] <= 8'h00;
      end
      byte_count <= '0;
      last_cr    <= 1'b0;
    end else if (cmd.accept) begin
      priority if (is_start) begin
        frame_buf[0] <= rx_byte;
        byte_count   <= CNT_W'(1);
        last_cr      <= 1'b0;
      end else if (!is_end) begin
        frame_buf[byte_count] <= rx_byte;
        last_cr               <= (rx_byte == CR_CHAR);
        if (byte_count == CNT_W'(MAX_FRAME_BYTES - 1)) begin
          byte_count <= '0;
        end else begin
          byte_count <= byte_count + CNT_W'(1);
        end
      end else if (end_ok) begin
        frame_buf[byte_count] <= rx_byte;
        byte_count            <= '0;
        last_cr               <= 1'b0;
      end else begin
        byte_count <= '0;
      end
    end
  end

  // buffer walk
  always_ff @(posedge clk) begin
    if (cmd.accept && end_ok) begin
      end_count <= byte_count;
      walk_idx  <= '0;
      lrc_sum   <= 8'h00;
    end else if (cmd.walk) begin
      walk_idx <= walk_idx + CNT_W'(1);
      if (in_sum) begin
        lrc_sum <= lrc_sum + walk_byte;
      end
      if ((idx_ext + EXT_W'(3)) == end_ext) begin
        got_hi <= walk_byte;
      end
      if ((idx_ext + EXT_W'(2)) == end_ext) begin
        got_lo <= walk_byte;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      frame_status <= status_val;
      command_byte <= frame_buf[1];
      address_byte <= frame_buf[2];
      data_byte_0  <= frame_buf[3];
      data_byte_1  <= frame_buf[4];
      data_byte_2  <= frame_buf[5];
      frame_length <= len_sum[3:0];
      computed_lrc <= (status_val == FS_TOO_SHORT) ? 16'h0000 : lrc_chars;
    end
  end

endmodule

/* rtl/core/ascii_frame_receiver_lrc_check.sv */
// ----------------------------------------------------------------------------
// ascii_frame_receiver_lrc_check
// ascii frame receiver with lrc8 check and address match
// ----------------------------------------------------------------------------
// bytes from the serial line come in one request at a time; 0x40 opens a
// frame, 0x09 right after 0x0d closes it, and a frame that fills the buffer
// is dropped. an ordinary byte is taken in idle. a closing byte of a frame
// holding n stored bytes goes through intake, one buffer read per stored
// byte for the lrc walk, and the result load; intake stalls meanwhile. at
// most MAX_FRAME_BYTES - 1 bytes are stored ahead of the close. the result
// load also waits while an earlier result is still held and stalled. the
// result sits in an output register, so the next byte is taken while it
// waits.
module ascii_frame_receiver_lrc_check
  import afrlrc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 10
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: own address character
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // received byte requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // frame result requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [7:0]  command_byte,
  output logic [7:0]  address_byte,
  output logic [7:0]  data_byte_0,
  output logic [7:0]  data_byte_1,
  output logic [7:0]  data_byte_2,
  output logic [3:0]  frame_length,
  output logic [15:0] computed_lrc
);

  afrlrc_cmd_t cmd;
  afrlrc_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: idle intake, buffer walk, result load
  afrlrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // buffer, lrc accumulator, status compare and result register
  afrlrc_dp #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .rx_byte      (rx_byte),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status),
    .command_byte (command_byte),
    .address_byte (address_byte),
    .data_byte_0  (data_byte_0),
    .data_byte_1  (data_byte_1),
    .data_byte_2  (data_byte_2),
    .frame_length (frame_length),
    .computed_lrc (computed_lrc)
  );

endmodule
